>>> rtl/core/tpf_pkg.sv
package tpf_pkg;

    localparam int TILE_W_DEF      = 64;
    localparam int TILE_H_DEF      = 64;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_WRAP  = 3'd1;
    localparam logic [2:0] MODE_SMEAR = 3'd2;
    localparam logic [2:0] MODE_BLACK = 3'd3;
    localparam logic [2:0] MODE_BG    = 3'd4;

    localparam logic [2:0] REG_EDGE_MODE  = 3'd0;
    localparam logic [2:0] REG_BPP        = 3'd1;
    localparam logic [2:0] REG_WIDTH      = 3'd2;
    localparam logic [2:0] REG_HEIGHT     = 3'd3;
    localparam logic [2:0] REG_SEL_X      = 3'd4;
    localparam logic [2:0] REG_SEL_Y      = 3'd5;
    localparam logic [2:0] REG_BACKGROUND = 3'd6;

    localparam logic [1:0] ACT_SKIP  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_CONST = 2'd3;

    localparam logic [1:0] CMD_SKIP   = 2'd0;
    localparam logic [1:0] CMD_CONST  = 2'd1;
    localparam logic [1:0] CMD_ACCESS = 2'd2;
    localparam logic [1:0] CMD_WRAP   = 2'd3;

    localparam logic [7:0] BYTE_ONES = 8'd255;

    // effective configuration: bpp clamped to 1..4, sizes forced nonzero
    typedef struct packed {
        logic [2:0]  mode;
        logic [2:0]  bpp;
        logic [15:0] width;
        logic [15:0] height;
        logic [31:0] sel_x;
        logic [31:0] sel_y;
        logic [31:0] bg;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        put;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] pix;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] tile_column;
        logic [15:0] tile_row;
        logic [13:0] byte_offset;
        logic        fetch_tile;
        logic        release_tile;
        logic        release_dirty;
        logic [31:0] pixel_data;
    } res_t;

    function automatic logic [31:0] byte_mask(input logic [2:0] bpp);
        logic [31:0] m;
        case (bpp)
            3'd1:    m = {24'b0, BYTE_ONES};
            3'd2:    m = {16'b0, BYTE_ONES, BYTE_ONES};
            3'd3:    m = {8'b0, BYTE_ONES, BYTE_ONES, BYTE_ONES};
            default: m = {BYTE_ONES, BYTE_ONES, BYTE_ONES, BYTE_ONES};
        endcase
        return m;
    endfunction

endpackage

>>> rtl/core/tpf_front.sv
module tpf_front
(
    input  tpf_pkg::cfg_t       cfg,
    input  logic                func,
    input  logic signed [31:0]  coord_x,
    input  logic signed [31:0]  coord_y,
    input  logic [31:0]         pixel_in,
    output tpf_pkg::cmd_t       cmd
);

    logic signed [32:0] x_s;
    logic signed [32:0] y_s;
    logic signed [32:0] sx1_s;
    logic signed [32:0] sx2_s;
    logic signed [32:0] sy1_s;
    logic signed [32:0] sy2_s;
    logic signed [32:0] w_s;
    logic signed [32:0] h_s;
    logic               out_sel;
    logic               out_img;
    logic [15:0]        clamp_x;
    logic [15:0]        clamp_y;
    logic [31:0]        mask;

    assign x_s   = $signed({coord_x[31], coord_x});
    assign y_s   = $signed({coord_y[31], coord_y});
    assign sx1_s = $signed({17'b0, cfg.sel_x[15:0]});
    assign sx2_s = $signed({17'b0, cfg.sel_x[31:16]});
    assign sy1_s = $signed({17'b0, cfg.sel_y[15:0]});
    assign sy2_s = $signed({17'b0, cfg.sel_y[31:16]});
    assign w_s   = $signed({17'b0, cfg.width});
    assign h_s   = $signed({17'b0, cfg.height});

    assign out_sel = (x_s < sx1_s) || (x_s >= sx2_s) || (y_s < sy1_s) || (y_s >= sy2_s);
    assign out_img = coord_x[31] || (x_s >= w_s) || coord_y[31] || (y_s >= h_s);

    assign clamp_x = coord_x[31] ? 16'd0 :
                     (x_s >= w_s) ? (cfg.width - 16'd1) : coord_x[15:0];
    assign clamp_y = coord_y[31] ? 16'd0 :
                     (y_s >= h_s) ? (cfg.height - 16'd1) : coord_y[15:0];

    assign mask = tpf_pkg::byte_mask(cfg.bpp);

    always_comb
    begin
        cmd.kind = tpf_pkg::CMD_SKIP;
        cmd.put  = func;
        cmd.x    = coord_x;
        cmd.y    = coord_y;
        cmd.pix  = '0;
        if (func)
        begin
            if (!out_sel && !out_img)
            begin
                cmd.kind = tpf_pkg::CMD_ACCESS;
                cmd.pix  = pixel_in & mask;
            end
        end
        else if (cfg.mode == tpf_pkg::MODE_NONE && out_sel)
        begin
            cmd.kind = tpf_pkg::CMD_SKIP;
        end
        else if (out_img)
        begin
            case (cfg.mode)
                tpf_pkg::MODE_WRAP:
                begin
                    cmd.kind = tpf_pkg::CMD_WRAP;
                end
                tpf_pkg::MODE_SMEAR:
                begin
                    cmd.kind = tpf_pkg::CMD_ACCESS;
                    cmd.x    = {16'b0, clamp_x};
                    cmd.y    = {16'b0, clamp_y};
                end
                tpf_pkg::MODE_BLACK:
                begin
                    cmd.kind = tpf_pkg::CMD_CONST;
                end
                tpf_pkg::MODE_BG:
                begin
                    cmd.kind = tpf_pkg::CMD_CONST;
                    cmd.pix  = cfg.bg & mask;
                end
                default:
                begin
                    cmd.kind = tpf_pkg::CMD_SKIP;
                end
            endcase
        end
        else
        begin
            cmd.kind = tpf_pkg::CMD_ACCESS;
        end
    end

endmodule

>>> rtl/core/tpf_queue.sv
module tpf_queue
#(
    parameter int DEPTH = tpf_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tpf_pkg::cmd_t din,
    output logic          full,
    input  logic          pop,
    output tpf_pkg::cmd_t dout,
    output logic          empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tpf_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> rtl/core/tpf_div.sv
module tpf_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] remainder
);

    // radix-4 restoring divider: two quotient bits per cycle
    localparam int STEPS = 16;

    logic [31:0] quo_reg;
    logic [15:0] rem_reg;
    logic [15:0] div_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [47:0] step1;
    logic [47:0] step2;

    function automatic logic [47:0] div_step(input logic [15:0] r, input logic [31:0] q,
                                             input logic [15:0] d);
        logic [16:0] t;
        logic [16:0] diff;
        logic [15:0] r_n;
        logic        bit_n;
        t    = {r, q[31]};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d})
        begin
            r_n   = diff[15:0];
            bit_n = 1'b1;
        end
        else
        begin
            r_n   = t[15:0];
            bit_n = 1'b0;
        end
        return {r_n, q[30:0], bit_n};
    endfunction

    assign step1 = div_step(rem_reg, quo_reg, div_reg);
    assign step2 = div_step(step1[47:32], step1[31:0], div_reg);

    assign done      = done_reg;
    assign remainder = rem_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= step2[31:0];
            rem_reg <= step2[47:32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'(STEPS - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/core/tpf_back.sv
module tpf_back
#(
    parameter int TILE_W = tpf_pkg::TILE_W_DEF,
    parameter int TILE_H = tpf_pkg::TILE_H_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  tpf_pkg::cfg_t cfg,
    input  logic          q_empty,
    input  tpf_pkg::cmd_t q_data,
    output logic          q_pop,
    input  logic          pop,
    output logic          empty,
    output tpf_pkg::res_t res
);

    localparam int COL_OFF_W = $clog2(TILE_W);
    localparam int ROW_OFF_W = $clog2(TILE_H);
    localparam int EW_W      = $clog2(TILE_W + 1);
    localparam int PROD_W    = EW_W + ROW_OFF_W + 1;

    // reciprocal multiply, exact for 16-bit coordinates
    localparam int          COL_SH    = 16 + $clog2(TILE_W);
    localparam int          ROW_SH    = 16 + $clog2(TILE_H);
    localparam logic [17:0] COL_RECIP =
        18'(((64'd1 << COL_SH) + 64'(TILE_W) - 64'd1) / 64'(TILE_W));
    localparam logic [17:0] ROW_RECIP =
        18'(((64'd1 << ROW_SH) + 64'(TILE_H) - 64'd1) / 64'(TILE_H));

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WRAP = 3'd1;
    localparam logic [2:0] S_TDIV = 3'd2;
    localparam logic [2:0] S_EW   = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_OFF  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic                 put_reg;
    logic [31:0]          pix_reg;
    logic                 xneg_reg;
    logic                 yneg_reg;
    logic [15:0]          tx_reg;
    logic [15:0]          ty_reg;
    logic [15:0]          col_reg;
    logic [15:0]          row_reg;
    logic [COL_OFF_W-1:0] coloff_reg;
    logic [ROW_OFF_W-1:0] rowoff_reg;
    logic [EW_W-1:0]      ew_reg;
    logic [13:0]          prod_reg;
    tpf_pkg::res_t        res_reg;
    tpf_pkg::res_t        out_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [15:0]          held_col_reg;
    logic [15:0]          held_row_reg;
    logic                 held_reg;
    logic                 dirty_reg;

    logic                 div_start;
    logic                 x_done;
    logic                 y_done;
    logic [15:0]          x_rem;
    logic [15:0]          y_rem;
    logic                 div_done;

    logic [31:0]          x_abs;
    logic [31:0]          y_abs;
    logic [15:0]          x_wrapped;
    logic [15:0]          y_wrapped;
    logic [33:0]          x_prod;
    logic [33:0]          y_prod;
    logic [15:0]          col_quo;
    logic [15:0]          row_quo;
    logic [23:0]          col_base;
    logic [23:0]          row_base;
    logic [23:0]          x_sub;
    logic [23:0]          y_sub;
    logic [23:0]          ew_diff;
    logic [EW_W-1:0]      ew_calc;
    logic                 miss;
    logic [PROD_W-1:0]    prod_full;
    logic [16:0]          off_full;
    logic                 load_out;
    tpf_pkg::res_t        res_early;
    tpf_pkg::res_t        res_acc;

    tpf_div u_div_x
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (x_abs),
        .divisor   (cfg.width),
        .done      (x_done),
        .remainder (x_rem)
    );

    tpf_div u_div_y
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (y_abs),
        .divisor   (cfg.height),
        .done      (y_done),
        .remainder (y_rem)
    );

    assign div_done = x_done && y_done;

    assign x_abs = q_data.x[31] ? (~q_data.x + 32'd1) : q_data.x;
    assign y_abs = q_data.y[31] ? (~q_data.y + 32'd1) : q_data.y;

    // C-style remainder of a negative value moves up by the modulus
    assign x_wrapped = (xneg_reg && x_rem != '0) ? (cfg.width - x_rem) : x_rem;
    assign y_wrapped = (yneg_reg && y_rem != '0) ? (cfg.height - y_rem) : y_rem;

    assign x_prod  = 34'(tx_reg) * 34'(COL_RECIP);
    assign y_prod  = 34'(ty_reg) * 34'(ROW_RECIP);
    assign col_quo = 16'(x_prod >> COL_SH);
    assign row_quo = 16'(y_prod >> ROW_SH);

    assign col_base = 24'(col_reg) * 24'(TILE_W);
    assign row_base = 24'(row_reg) * 24'(TILE_H);
    assign x_sub    = 24'(tx_reg) - col_base;
    assign y_sub    = 24'(ty_reg) - row_base;

    // edge tiles are narrower
    assign ew_diff  = 24'(cfg.width) - col_base;
    assign ew_calc  = (ew_diff > 24'(TILE_W)) ? EW_W'(TILE_W) : EW_W'(ew_diff);

    assign miss = (col_reg != held_col_reg) || (row_reg != held_row_reg) || !held_reg;

    assign prod_full = PROD_W'(ew_reg) * PROD_W'(rowoff_reg) + PROD_W'(coloff_reg);
    assign off_full  = 17'(cfg.bpp) * 17'(prod_reg);

    assign load_out = (state_reg == S_OUT) && (!out_valid_reg || pop);

    assign empty = !out_valid_reg;
    assign res   = out_reg;

    always_comb
    begin
        res_early            = '0;
        res_early.action     = (q_data.kind == tpf_pkg::CMD_CONST) ?
                               tpf_pkg::ACT_CONST : tpf_pkg::ACT_SKIP;
        res_early.pixel_data = q_data.pix;

        res_acc               = '0;
        res_acc.action        = put_reg ? tpf_pkg::ACT_WRITE : tpf_pkg::ACT_READ;
        res_acc.tile_column   = col_reg;
        res_acc.tile_row      = row_reg;
        res_acc.fetch_tile    = miss;
        res_acc.release_tile  = miss && held_reg;
        res_acc.release_dirty = miss && held_reg && dirty_reg;
        res_acc.pixel_data    = pix_reg;
    end

    always_comb
    begin
        div_start = 1'b0;
        q_pop     = 1'b0;
        if (state_reg == S_IDLE && !q_empty)
        begin
            q_pop     = 1'b1;
            div_start = (q_data.kind == tpf_pkg::CMD_WRAP);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_data.kind)
                        tpf_pkg::CMD_WRAP:   state_next = S_WRAP;
                        tpf_pkg::CMD_ACCESS: state_next = S_TDIV;
                        default:             state_next = S_OUT;
                    endcase
                end
            end
            S_WRAP:  state_next = div_done ? S_TDIV : S_WRAP;
            S_TDIV:  state_next = S_EW;
            S_EW:    state_next = S_MUL;
            S_MUL:   state_next = S_OFF;
            S_OFF:   state_next = S_OUT;
            S_OUT:   state_next = load_out ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !pop;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    put_reg  <= q_data.put;
                    pix_reg  <= q_data.pix;
                    xneg_reg <= q_data.x[31];
                    yneg_reg <= q_data.y[31];
                    tx_reg   <= q_data.x[15:0];
                    ty_reg   <= q_data.y[15:0];
                    res_reg  <= res_early;
                end
            end
            S_WRAP:
            begin
                if (div_done)
                begin
                    tx_reg <= x_wrapped;
                    ty_reg <= y_wrapped;
                end
            end
            S_TDIV:
            begin
                col_reg <= col_quo;
                row_reg <= row_quo;
            end
            S_EW:
            begin
                ew_reg     <= ew_calc;
                coloff_reg <= x_sub[COL_OFF_W-1:0];
                rowoff_reg <= y_sub[ROW_OFF_W-1:0];
                res_reg    <= res_acc;
            end
            S_MUL:
            begin
                prod_reg <= 14'(prod_full);
            end
            S_OFF:
            begin
                res_reg.byte_offset <= off_full[13:0];
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            held_col_reg  <= '1;
            held_row_reg  <= '1;
            held_reg      <= 1'b0;
            dirty_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == S_EW)
            begin
                if (miss)
                begin
                    held_col_reg <= col_reg;
                    held_row_reg <= row_reg;
                    held_reg     <= 1'b1;
                    dirty_reg    <= put_reg;
                end
                else if (put_reg)
                begin
                    dirty_reg <= 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/core/tiled_pixel_fetch_edge_addressing_core.sv
// Channel   Direction  Handshake            Word
// config    in         cfg_write            cfg_index, cfg_data
// request   in         push / full          func, coord_x, coord_y, pixel_in
// result    out        pop / empty          action .. pixel_data
//
// Skip and constant words go straight to S_OUT, tile accesses pass S_TDIV..S_OFF first;
// a wrapped get waits longest, on the 16-step radix-4 divider for the wrap modulo.
// The back end takes one word at a time. A 2-entry queue lets requests land
// while the back end works, and the output register holds one word while pop is low.
// Reset returns the config registers to their defaults, empties the queue and clears the held tile tag.
module tiled_pixel_fetch_edge_addressing_core
#(
    parameter int TILE_W      = tpf_pkg::TILE_W_DEF,
    parameter int TILE_H      = tpf_pkg::TILE_H_DEF,
    parameter int QUEUE_DEPTH = tpf_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               push,
    output logic               full,
    input  logic               func,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic [31:0]        pixel_in,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         action,
    output logic [15:0]        tile_column,
    output logic [15:0]        tile_row,
    output logic [13:0]        byte_offset,
    output logic               fetch_tile,
    output logic               release_tile,
    output logic               release_dirty,
    output logic [31:0]        pixel_data
);

    logic [2:0]    mode_reg;
    logic [2:0]    bpp_reg;
    logic [15:0]   width_reg;
    logic [15:0]   height_reg;
    logic [31:0]   selx_reg;
    logic [31:0]   sely_reg;
    logic [31:0]   bg_reg;
    tpf_pkg::cfg_t cfg_eff;
    tpf_pkg::cmd_t cmd;
    tpf_pkg::cmd_t q_data;
    logic          q_empty;
    logic          q_pop;
    tpf_pkg::res_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= tpf_pkg::MODE_NONE;
            bpp_reg    <= 3'd4;
            width_reg  <= 16'd1;
            height_reg <= 16'd1;
            selx_reg   <= '0;
            sely_reg   <= '0;
            bg_reg     <= {tpf_pkg::BYTE_ONES, 24'b0};
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tpf_pkg::REG_EDGE_MODE:  mode_reg   <= cfg_data[2:0];
                tpf_pkg::REG_BPP:        bpp_reg    <= cfg_data[2:0];
                tpf_pkg::REG_WIDTH:      width_reg  <= cfg_data[15:0];
                tpf_pkg::REG_HEIGHT:     height_reg <= cfg_data[15:0];
                tpf_pkg::REG_SEL_X:      selx_reg   <= cfg_data;
                tpf_pkg::REG_SEL_Y:      sely_reg   <= cfg_data;
                tpf_pkg::REG_BACKGROUND: bg_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg_eff.mode   = mode_reg;
        cfg_eff.bpp    = (bpp_reg == 3'd0) ? 3'd1 : ((bpp_reg > 3'd4) ? 3'd4 : bpp_reg);
        cfg_eff.width  = (width_reg == '0) ? 16'd1 : width_reg;
        cfg_eff.height = (height_reg == '0) ? 16'd1 : height_reg;
        cfg_eff.sel_x  = selx_reg;
        cfg_eff.sel_y  = sely_reg;
        cfg_eff.bg     = bg_reg;
    end

    tpf_front u_front
    (
        .cfg      (cfg_eff),
        .func     (func),
        .coord_x  (coord_x),
        .coord_y  (coord_y),
        .pixel_in (pixel_in),
        .cmd      (cmd)
    );

    tpf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (cmd),
        .full  (full),
        .pop   (q_pop),
        .dout  (q_data),
        .empty (q_empty)
    );

    tpf_back #(.TILE_W(TILE_W), .TILE_H(TILE_H)) u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_eff),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .res     (res)
    );

    assign action        = res.action;
    assign tile_column   = res.tile_column;
    assign tile_row      = res.tile_row;
    assign byte_offset   = res.byte_offset;
    assign fetch_tile    = res.fetch_tile;
    assign release_tile  = res.release_tile;
    assign release_dirty = res.release_dirty;
    assign pixel_data    = res.pixel_data;

    a_no_tile_on_skip_const: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (action == tpf_pkg::ACT_SKIP || action == tpf_pkg::ACT_CONST)
        |-> !fetch_tile && !release_tile && !release_dirty &&
            tile_column == '0 && tile_row == '0 && byte_offset == '0)
        else $error("tile fields set on skipped or constant word");

    a_release_needs_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (release_dirty || release_tile) |-> fetch_tile &&
            (release_tile || !release_dirty))
        else $error("release without fetch");

    a_read_has_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && action == tpf_pkg::ACT_READ |-> pixel_data == '0)
        else $error("read word carries pixel data");

endmodule
